@@ hdl/twsm_pkg.sv @@
// ----------------------------------------------------------------------------
// twsm_pkg
// Shared codes and types of the timestep window slot manager.
// ----------------------------------------------------------------------------
package twsm_pkg;

   // Field widths
   localparam int TS_W    = 23;
   localparam int STAMP_W = 48;

   // Slot status codes
   localparam logic [1:0] ST_FREE     = 2'd0;
   localparam logic [1:0] ST_PENDING  = 2'd1;
   localparam logic [1:0] ST_RESIDENT = 2'd2;

   // Input word kinds
   localparam logic [2:0] K_PLAYHEAD = 3'd0;
   localparam logic [2:0] K_SAMPLE   = 3'd1;
   localparam logic [2:0] K_QUERY    = 3'd2;
   localparam logic [2:0] K_LOADDONE = 3'd3;
   localparam logic [2:0] K_FRAME    = 3'd4;

   // Result word codes
   localparam logic [2:0] R_LOAD     = 3'd0;
   localparam logic [2:0] R_EXACT    = 3'd1;
   localparam logic [2:0] R_LASTGOOD = 3'd2;
   localparam logic [2:0] R_KEYFRAME = 3'd3;
   localparam logic [2:0] R_NONE     = 3'd4;
   localparam logic [2:0] R_PRESENT  = 3'd5;
   localparam logic [2:0] R_ABSENT   = 3'd6;
   localparam logic [2:0] R_DONE     = 3'd7;

   // Register indexes
   localparam logic [1:0] CSR_ENABLED   = 2'd0;
   localparam logic [1:0] CSR_NUM_TS    = 2'd1;
   localparam logic [1:0] CSR_STRIDE    = 2'd2;
   localparam logic [1:0] CSR_LOOKAHEAD = 2'd3;

   // Outcome of one pass over the slot table
   typedef struct packed {
      logic match_found;
      logic match_resident;
      logic alloc_ok;
   } scan_res_type;

   // Write command into the slot table
   typedef struct packed {
      logic               en_a;
      logic               en_b;
      logic [1:0]         status;
      logic [TS_W-1:0]    ts;
      logic [STAMP_W-1:0] stamp;
      logic               served;
   } wr_type;

endpackage

@@ hdl/twsm_div.sv @@
// ----------------------------------------------------------------------------
// twsm_div
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module twsm_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [22:0] dividend,
   input  logic [22:0] divisor,
   output logic        done,
   output logic [22:0] rem
);

   localparam logic [4:0] STEPS = 5'd23;

   logic        busy_ff, busy_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [22:0] rem_ff, rem_in;
   logic [22:0] dd_ff, dd_in;
   logic [23:0] trial;
   logic [23:0] diff;

   // One shift and conditional subtract per cycle
   always_comb begin
      trial   = {rem_ff, dd_ff[22]};
      diff    = trial - {1'b0, divisor};
      done    = busy_ff && (cnt_ff == 5'd0);
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dd_in   = dd_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = STEPS;
         rem_in  = '0;
         dd_in   = dividend;
      end else if (busy_ff && cnt_ff != 5'd0) begin
         cnt_in = cnt_ff - 5'd1;
         rem_in = (trial >= {1'b0, divisor}) ? diff[22:0] : trial[22:0];
         dd_in  = {dd_ff[21:0], 1'b0};
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dd_ff  <= dd_in;
   end

   assign rem = rem_ff;

endmodule

@@ hdl/twsm_scan.sv @@
// ----------------------------------------------------------------------------
// twsm_scan
// Slot table memories and the sweep that finds a timestep, a free slot and
// the least recently used evictable slot.
// ----------------------------------------------------------------------------
module twsm_scan #(
   parameter int SLOTS = 128,
   localparam int IW = $clog2(SLOTS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [22:0]            target,
   input  logic [23:0]            pin_a,
   input  logic [23:0]            pin_b,
   input  logic                   rd_en,
   input  logic [IW-1:0]          rd_addr,
   input  twsm_pkg::wr_type       wr,
   input  logic [IW-1:0]          wr_addr,
   output logic                   done,
   output twsm_pkg::scan_res_type res,
   output logic [IW-1:0]          match_idx,
   output logic [IW-1:0]          alloc_idx,
   output logic [1:0]             rd_status,
   output logic [22:0]            rd_ts,
   output logic [47:0]            rd_stamp
);

   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [CW-1:0] CNT_END = CW'(SLOTS);
   localparam int AW = 2 + twsm_pkg::TS_W + twsm_pkg::STAMP_W;

   logic [AW-1:0] mem_a [SLOTS];
   logic          mem_b [SLOTS];
   logic [AW-1:0] rda_ff;
   logic          rdb_ff;
   logic [IW-1:0] raddr;

   logic          run_ff, run_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          vld_ff;
   logic [IW-1:0] didx_ff;
   logic          issue;

   logic          mf_ff, mf_in, mres_ff, mres_in;
   logic [IW-1:0] midx_ff, midx_in;
   logic          free_ff, free_in;
   logic [IW-1:0] fidx_ff, fidx_in;
   logic          lf_ff, lf_in;
   logic [IW-1:0] lidx_ff, lidx_in;
   logic [47:0]   lstamp_ff, lstamp_in;

   logic [1:0]    e_status;
   logic [22:0]   e_ts;
   logic [47:0]   e_stamp;
   logic          cand;

   assign raddr = run_ff ? cnt_ff[IW-1:0] : rd_addr;

   // Table storage: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr.en_a) begin
         mem_a[wr_addr] <= {wr.status, wr.ts, wr.stamp};
      end
      if (wr.en_b) begin
         mem_b[wr_addr] <= wr.served;
      end
      if (run_ff || rd_en) begin
         rda_ff <= mem_a[raddr];
         rdb_ff <= mem_b[raddr];
      end
   end

   // Advance the sweep and fold each entry into the running results
   always_comb begin
      issue    = run_ff && (cnt_ff != CNT_END);
      done     = run_ff && !issue && !vld_ff;
      run_in   = start ? 1'b1 : (done ? 1'b0 : run_ff);
      cnt_in   = start ? '0 : (issue ? cnt_ff + CW'(1) : cnt_ff);
      e_status = rda_ff[AW-1 -: 2];
      e_ts     = rda_ff[AW-3 -: twsm_pkg::TS_W];
      e_stamp  = rda_ff[twsm_pkg::STAMP_W-1:0];
      cand     = (e_status == twsm_pkg::ST_RESIDENT) && ({1'b0, e_ts} != pin_a)
                 && ({1'b0, e_ts} != pin_b) && !rdb_ff;
      mf_in     = mf_ff;
      mres_in   = mres_ff;
      midx_in   = midx_ff;
      free_in   = free_ff;
      fidx_in   = fidx_ff;
      lf_in     = lf_ff;
      lidx_in   = lidx_ff;
      lstamp_in = lstamp_ff;
      if (start) begin
         mf_in   = 1'b0;
         free_in = 1'b0;
         lf_in   = 1'b0;
      end else if (vld_ff) begin
         if (!mf_ff && e_status != twsm_pkg::ST_FREE && e_ts == target) begin
            mf_in   = 1'b1;
            mres_in = (e_status == twsm_pkg::ST_RESIDENT);
            midx_in = didx_ff;
         end
         if (!free_ff && e_status == twsm_pkg::ST_FREE) begin
            free_in = 1'b1;
            fidx_in = didx_ff;
         end
         if (cand && (!lf_ff || e_stamp < lstamp_ff)) begin
            lf_in     = 1'b1;
            lidx_in   = didx_ff;
            lstamp_in = e_stamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         vld_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         vld_ff <= issue;
         cnt_ff <= cnt_in;
      end
      didx_ff   <= cnt_ff[IW-1:0];
      mf_ff     <= mf_in;
      mres_ff   <= mres_in;
      midx_ff   <= midx_in;
      free_ff   <= free_in;
      fidx_ff   <= fidx_in;
      lf_ff     <= lf_in;
      lidx_ff   <= lidx_in;
      lstamp_ff <= lstamp_in;
   end

   assign res.match_found    = mf_ff;
   assign res.match_resident = mres_ff;
   assign res.alloc_ok       = free_ff || lf_ff;
   assign match_idx          = midx_ff;
   assign alloc_idx          = free_ff ? fidx_ff : lidx_ff;
   assign rd_status          = rda_ff[AW-1 -: 2];
   assign rd_ts              = rda_ff[AW-3 -: twsm_pkg::TS_W];
   assign rd_stamp           = rda_ff[twsm_pkg::STAMP_W-1:0];

endmodule

@@ hdl/timestep_window_slot_manager_unit.sv @@
// ----------------------------------------------------------------------------
// timestep_window_slot_manager_unit
// Slot cache manager for timestep blocks: playhead prefetch, sample serving,
// load completion and per-frame bookkeeping.
// ----------------------------------------------------------------------------
// Every lookup or load request is one pass over the slot table in memory,
// one entry per cycle, with the keyframe remainder unit running alongside.
// A playhead word takes up to 62 such passes; a sample word takes up to
// three passes; a query at most one pass. A frame advance walks every slot
// once, as does the clearing pass after reset (no word is accepted during the
// clearing pass). One input word is worked on at a time; the result register
// lets the next word in while the last result still waits.
// ----------------------------------------------------------------------------
module timestep_window_slot_manager_unit #(
   parameter int SLOTS = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [23:0] req_ts,
   input  logic [1:0]  req_direction,
   input  logic [6:0]  req_done_slot,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_response,
   output logic [6:0]  rsp_slot,
   output logic [22:0] rsp_out_ts,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [22:0] csr_wdata
);

   localparam int IW = $clog2(SLOTS);
   localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);
   localparam logic [5:0] LOOK_CAP = 6'((SLOTS / 2 < 60) ? SLOTS / 2 : 60);

   localparam logic [3:0] S_CLR    = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_DISP   = 4'd2;
   localparam logic [3:0] S_PHNEXT = 4'd3;
   localparam logic [3:0] S_WAIT   = 4'd4;
   localparam logic [3:0] S_PHREQ  = 4'd5;
   localparam logic [3:0] S_LOAD   = 4'd6;
   localparam logic [3:0] S_SMP1   = 4'd7;
   localparam logic [3:0] S_SMPLG  = 4'd8;
   localparam logic [3:0] S_SMP2   = 4'd9;
   localparam logic [3:0] S_KMAX   = 4'd10;
   localparam logic [3:0] S_SMP3   = 4'd11;
   localparam logic [3:0] S_QRY    = 4'd12;
   localparam logic [3:0] S_CMPL   = 4'd13;
   localparam logic [3:0] S_SWEEP  = 4'd14;
   localparam logic [3:0] S_FIN    = 4'd15;

   logic [3:0]  state_ff, state_in, ret_ff, ret_in;
   logic        en_ff;
   logic [22:0] nts_ff, stride_ff;
   logic [5:0]  look_ff;
   logic [2:0]  kind_ff;
   logic [23:0] ts_ff;
   logic [1:0]  dir_ff;
   logic [6:0]  dslot_ff;
   logic [23:0] pin1_ff, pin1_in, pin2_ff, pin2_in, lg_ff, lg_in;
   logic [47:0] uc_ff, uc_in;
   logic [6:0]  n_ff, n_in, total_ff, total_in;
   logic [25:0] tgt_ff, tgt_in;
   logic [22:0] remts_ff, remts_in;
   logic [IW-1:0] clr_ff, clr_in;
   logic        start_ff, start_in, sdone_ff, sdone_in, ddone_ff, ddone_in;
   logic        rv_ff, rv_in, rlast_ff, rlast_in;
   logic [2:0]  rresp_ff, rresp_in;
   logic [IW-1:0] rslot_ff, rslot_in;
   logic [22:0] rts_ff, rts_in;
   logic [2:0]  eresp_ff, eresp_in;
   logic [IW-1:0] eslot_ff, eslot_in;
   logic [22:0] ets_ff, ets_in;

   logic                   scan_done, div_done;
   twsm_pkg::scan_res_type sres;
   logic [IW-1:0]          match_idx, alloc_idx;
   logic [1:0]             rd_status;
   logic [22:0]            rd_ts, div_rem, stride_eff;
   logic [47:0]            rd_stamp, uc_next;
   logic                   rd_en;
   logic [IW-1:0]          rd_addr, wr_addr;
   twsm_pkg::wr_type       wr;

   logic        out_free, tgt_ok, ph_ok, round_up;
   logic [5:0]  look_eff;
   logic [6:0]  m, dd;
   logic [7:0]  off;
   logic [25:0] ph_tgt, ts_wide;
   logic [24:0] kf;
   logic [22:0] kmax;

   twsm_scan #(.SLOTS(SLOTS)) u_scan (
      .clock     (clock),
      .reset     (reset),
      .start     (start_ff),
      .target    (tgt_ff[22:0]),
      .pin_a     (pin1_ff),
      .pin_b     (pin2_ff),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .wr        (wr),
      .wr_addr   (wr_addr),
      .done      (scan_done),
      .res       (sres),
      .match_idx (match_idx),
      .alloc_idx (alloc_idx),
      .rd_status (rd_status),
      .rd_ts     (rd_ts),
      .rd_stamp  (rd_stamp)
   );

   twsm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend (tgt_ff[22:0]),
      .divisor  (stride_eff),
      .done     (div_done),
      .rem      (div_rem)
   );

   // Derived values
   always_comb begin
      stride_eff = (stride_ff == 23'd0) ? 23'd1 : stride_ff;
      look_eff   = (look_ff > LOOK_CAP) ? LOOK_CAP : look_ff;
      out_free   = !rv_ff || rsp_ready;
      uc_next    = uc_ff + 48'd1;
      tgt_ok     = !tgt_ff[25] && (tgt_ff[24:0] < {2'b00, nts_ff});
      ts_wide    = {{2{ts_ff[23]}}, ts_ff};
      // Offset of the n-th playhead request
      m  = n_ff - 7'd2;
      dd = {1'b0, m[6:1]} + 7'd1;
      if (n_ff == 7'd0) begin
         off = 8'd0;
      end else if (n_ff == 7'd1) begin
         off = 8'd1;
      end else if (dir_ff == 2'b01) begin
         off = {1'b0, n_ff};
      end else if (dir_ff[1]) begin
         off = 8'd1 - {1'b0, n_ff};
      end else begin
         off = m[0] ? -{1'b0, dd} : {1'b0, dd};
      end
      ph_tgt   = ts_wide + {{18{off[7]}}, off};
      ph_ok    = !ph_tgt[25] && (ph_tgt[24:0] < {2'b00, nts_ff});
      // Nearest keyframe, rounded half up and capped
      round_up = ({remts_ff, 1'b0} >= {1'b0, stride_eff});
      kf       = {2'b00, ts_ff[22:0]} - {2'b00, remts_ff}
                 + (round_up ? {2'b00, stride_eff} : 25'd0);
      kmax     = nts_ff - 23'd1 - div_rem;
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      pin1_in  = pin1_ff;
      pin2_in  = pin2_ff;
      lg_in    = lg_ff;
      uc_in    = uc_ff;
      n_in     = n_ff;
      total_in = total_ff;
      tgt_in   = tgt_ff;
      remts_in = remts_ff;
      clr_in   = clr_ff;
      start_in = 1'b0;
      eresp_in = eresp_ff;
      eslot_in = eslot_ff;
      ets_in   = ets_ff;
      rd_en    = 1'b0;
      rd_addr  = IW'(dslot_ff);
      wr       = '0;
      wr_addr  = '0;
      rv_in    = rv_ff && !rsp_ready;
      rresp_in = rresp_ff;
      rslot_in = rslot_ff;
      rts_in   = rts_ff;
      rlast_in = rlast_ff;

      unique case (state_ff)
         S_CLR: begin
            // Clear the table after reset
            wr.en_a = 1'b1;
            wr.en_b = 1'b1;
            wr.status = twsm_pkg::ST_FREE;
            wr_addr = clr_ff;
            clr_in  = clr_ff + IW'(1);
            if (clr_ff == LAST_SLOT) begin
               clr_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            eresp_in = twsm_pkg::R_DONE;
            eslot_in = '0;
            ets_in   = '0;
            tgt_in   = ts_wide;
            state_in = S_FIN;
            priority case (kind_ff)
               twsm_pkg::K_PLAYHEAD: begin
                  if (en_ff) begin
                     pin1_in = ts_ff;
                     pin2_in = ts_ff + 24'd1;
                     n_in    = '0;
                     if (dir_ff == 2'b01) begin
                        total_in = (look_eff >= 6'd2) ? {1'b0, look_eff} + 7'd1 : 7'd2;
                     end else if (dir_ff[1]) begin
                        total_in = {1'b0, look_eff} + 7'd2;
                     end else begin
                        total_in = {1'b0, look_eff[5:1], 1'b0} + 7'd2;
                     end
                     state_in = S_PHNEXT;
                  end
               end
               twsm_pkg::K_SAMPLE: begin
                  eresp_in = twsm_pkg::R_NONE;
                  if (en_ff && !ts_ff[23] && (ts_ff[22:0] < nts_ff)) begin
                     start_in = 1'b1;
                     ret_in   = S_SMP1;
                     state_in = S_WAIT;
                  end
               end
               twsm_pkg::K_QUERY: begin
                  eresp_in = twsm_pkg::R_ABSENT;
                  if (en_ff && !ts_ff[23] && (ts_ff[22:0] < nts_ff)) begin
                     start_in = 1'b1;
                     ret_in   = S_QRY;
                     state_in = S_WAIT;
                  end
               end
               twsm_pkg::K_LOADDONE: begin
                  if (32'(dslot_ff) < SLOTS) begin
                     rd_en    = 1'b1;
                     state_in = S_CMPL;
                  end
               end
               twsm_pkg::K_FRAME: begin
                  clr_in   = '0;
                  state_in = S_SWEEP;
               end
               default: begin
                  state_in = S_FIN;
               end
            endcase
         end
         S_PHNEXT: begin
            // Step through the prefetch window
            if (n_ff == total_ff) begin
               eresp_in = twsm_pkg::R_DONE;
               eslot_in = '0;
               ets_in   = '0;
               state_in = S_FIN;
            end else begin
               n_in   = n_ff + 7'd1;
               tgt_in = ph_tgt;
               if (ph_ok) begin
                  start_in = 1'b1;
                  ret_in   = S_PHREQ;
                  state_in = S_WAIT;
               end
            end
         end
         S_WAIT: begin
            if (sdone_ff && ddone_ff) begin
               state_in = ret_ff;
            end
         end
         S_PHREQ: begin
            state_in = S_PHNEXT;
            if (!sres.match_found && div_rem != 23'd0 && sres.alloc_ok) begin
               wr.en_a   = 1'b1;
               wr.en_b   = 1'b1;
               wr.status = twsm_pkg::ST_PENDING;
               wr.ts     = tgt_ff[22:0];
               wr.stamp  = uc_next;
               wr_addr   = alloc_idx;
               uc_in     = uc_next;
               eresp_in  = twsm_pkg::R_LOAD;
               eslot_in  = alloc_idx;
               ets_in    = tgt_ff[22:0];
               ret_in    = S_PHNEXT;
               state_in  = S_LOAD;
            end
         end
         S_LOAD: begin
            // Emit a load request word
            if (out_free) begin
               rv_in    = 1'b1;
               rresp_in = eresp_ff;
               rslot_in = eslot_ff;
               rts_in   = ets_ff;
               rlast_in = 1'b0;
               state_in = ret_ff;
            end
         end
         S_SMP1: begin
            remts_in = div_rem;
            if (sres.match_found && sres.match_resident) begin
               wr.en_a   = 1'b1;
               wr.en_b   = 1'b1;
               wr.status = twsm_pkg::ST_RESIDENT;
               wr.ts     = tgt_ff[22:0];
               wr.stamp  = uc_next;
               wr.served = 1'b1;
               wr_addr   = match_idx;
               uc_in     = uc_next;
               lg_in     = ts_ff;
               eresp_in  = twsm_pkg::R_EXACT;
               eslot_in  = match_idx;
               ets_in    = ts_ff[22:0];
               state_in  = S_FIN;
            end else if (sres.match_found) begin
               state_in = S_SMPLG;
            end else if (div_rem == 23'd0) begin
               lg_in    = ts_ff;
               eresp_in = twsm_pkg::R_KEYFRAME;
               eslot_in = '0;
               ets_in   = ts_ff[22:0];
               state_in = S_FIN;
            end else if (sres.alloc_ok) begin
               wr.en_a   = 1'b1;
               wr.en_b   = 1'b1;
               wr.status = twsm_pkg::ST_PENDING;
               wr.ts     = tgt_ff[22:0];
               wr.stamp  = uc_next;
               wr_addr   = alloc_idx;
               uc_in     = uc_next;
               eresp_in  = twsm_pkg::R_LOAD;
               eslot_in  = alloc_idx;
               ets_in    = tgt_ff[22:0];
               ret_in    = S_SMPLG;
               state_in  = S_LOAD;
            end else begin
               state_in = S_SMPLG;
            end
         end
         S_SMPLG: begin
            start_in = 1'b1;
            state_in = S_WAIT;
            if (!lg_ff[23]) begin
               tgt_in = {2'b00, lg_ff};
               ret_in = S_SMP2;
            end else begin
               tgt_in = {3'b000, nts_ff - 23'd1};
               ret_in = S_SMP3;
            end
         end
         S_SMP2: begin
            state_in = S_KMAX;
            if (sres.match_found && sres.match_resident) begin
               wr.en_a   = 1'b1;
               wr.en_b   = 1'b1;
               wr.status = twsm_pkg::ST_RESIDENT;
               wr.ts     = tgt_ff[22:0];
               wr.stamp  = uc_next;
               wr.served = 1'b1;
               wr_addr   = match_idx;
               uc_in     = uc_next;
               eresp_in  = twsm_pkg::R_LASTGOOD;
               eslot_in  = match_idx;
               ets_in    = tgt_ff[22:0];
               state_in  = S_FIN;
            end else if (!sres.match_found && tgt_ok && div_rem == 23'd0) begin
               eresp_in = twsm_pkg::R_KEYFRAME;
               eslot_in = '0;
               ets_in   = tgt_ff[22:0];
               state_in = S_FIN;
            end
         end
         S_KMAX: begin
            tgt_in   = {3'b000, nts_ff - 23'd1};
            start_in = 1'b1;
            ret_in   = S_SMP3;
            state_in = S_WAIT;
         end
         S_SMP3: begin
            eresp_in = twsm_pkg::R_KEYFRAME;
            eslot_in = '0;
            ets_in   = (kf > {2'b00, kmax}) ? kmax : kf[22:0];
            state_in = S_FIN;
         end
         S_QRY: begin
            eslot_in = '0;
            ets_in   = '0;
            state_in = S_FIN;
            if (sres.match_found && sres.match_resident) begin
               wr.en_a   = 1'b1;
               wr.en_b   = 1'b1;
               wr.status = twsm_pkg::ST_RESIDENT;
               wr.ts     = tgt_ff[22:0];
               wr.stamp  = uc_next;
               wr.served = 1'b1;
               wr_addr   = match_idx;
               uc_in     = uc_next;
               eresp_in  = twsm_pkg::R_PRESENT;
            end else if (!sres.match_found && div_rem == 23'd0) begin
               eresp_in = twsm_pkg::R_PRESENT;
            end else begin
               eresp_in = twsm_pkg::R_ABSENT;
            end
         end
         S_CMPL: begin
            // Promote a pending slot to resident
            if (rd_status == twsm_pkg::ST_PENDING) begin
               wr.en_a   = 1'b1;
               wr.status = twsm_pkg::ST_RESIDENT;
               wr.ts     = rd_ts;
               wr.stamp  = rd_stamp;
               wr_addr   = IW'(dslot_ff);
            end
            state_in = S_FIN;
         end
         S_SWEEP: begin
            // Drop every served flag
            wr.en_b = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + IW'(1);
            if (clr_ff == LAST_SLOT) begin
               clr_in   = '0;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               rv_in    = 1'b1;
               rresp_in = eresp_ff;
               rslot_in = eslot_ff;
               rts_in   = ets_ff;
               rlast_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      sdone_in = start_in ? 1'b0 : (scan_done ? 1'b1 : sdone_ff);
      ddone_in = start_in ? 1'b0 : (div_done ? 1'b1 : ddone_ff);
   end

   // Control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         ret_ff   <= S_IDLE;
         en_ff    <= 1'b0;
         nts_ff   <= '0;
         stride_ff <= 23'd1;
         look_ff  <= 6'd16;
         pin1_ff  <= '1;
         pin2_ff  <= '1;
         lg_ff    <= '1;
         uc_ff    <= '0;
         clr_ff   <= '0;
         start_ff <= 1'b0;
         sdone_ff <= 1'b0;
         ddone_ff <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         pin1_ff  <= pin1_in;
         pin2_ff  <= pin2_in;
         lg_ff    <= lg_in;
         uc_ff    <= uc_in;
         clr_ff   <= clr_in;
         start_ff <= start_in;
         sdone_ff <= sdone_in;
         ddone_ff <= ddone_in;
         rv_ff    <= rv_in;
         if (csr_valid) begin
            unique case (csr_index)
               twsm_pkg::CSR_ENABLED:   en_ff     <= csr_wdata[0];
               twsm_pkg::CSR_NUM_TS:    nts_ff    <= csr_wdata;
               twsm_pkg::CSR_STRIDE:    stride_ff <= csr_wdata;
               twsm_pkg::CSR_LOOKAHEAD: look_ff   <= csr_wdata[5:0];
               default:                 en_ff     <= en_ff;
            endcase
         end
      end
      if (state_ff == S_IDLE && req_valid) begin
         kind_ff  <= req_kind;
         ts_ff    <= req_ts;
         dir_ff   <= req_direction;
         dslot_ff <= req_done_slot;
      end
      n_ff     <= n_in;
      total_ff <= total_in;
      tgt_ff   <= tgt_in;
      remts_ff <= remts_in;
      eresp_ff <= eresp_in;
      eslot_ff <= eslot_in;
      ets_ff   <= ets_in;
      rresp_ff <= rresp_in;
      rslot_ff <= rslot_in;
      rts_ff   <= rts_in;
      rlast_ff <= rlast_in;
   end

   assign req_ready    = (state_ff == S_IDLE);
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rv_ff;
   assign rsp_response = rresp_ff;
   assign rsp_slot     = 7'(rslot_ff);
   assign rsp_out_ts   = rts_ff;
   assign rsp_last     = rlast_ff;

endmodule

@@ hdl/twsm_chk.sv @@
// ----------------------------------------------------------------------------
// twsm_chk
// Port-level checks of the slot manager's result words.
// ----------------------------------------------------------------------------
module twsm_chk (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_response,
   input logic [6:0]  rsp_slot,
   input logic [22:0] rsp_out_ts,
   input logic        rsp_last
);

   // Load requests never close an input; every other word does
   a_last_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_response != twsm_pkg::R_LOAD)))
      else $error("last flag does not match response code");

   // Responses without a slot carry slot zero
   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_response == twsm_pkg::R_KEYFRAME || rsp_response == twsm_pkg::R_NONE
      || rsp_response == twsm_pkg::R_PRESENT || rsp_response == twsm_pkg::R_ABSENT
      || rsp_response == twsm_pkg::R_DONE) |-> rsp_slot == 7'd0)
      else $error("slot set on a slotless response");

   // Status responses carry no timestep
   a_ts_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_response == twsm_pkg::R_NONE || rsp_response == twsm_pkg::R_PRESENT
      || rsp_response == twsm_pkg::R_ABSENT || rsp_response == twsm_pkg::R_DONE)
      |-> rsp_out_ts == 23'd0)
      else $error("timestep set on a status response");

   // Hold a stalled result word
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_response) && $stable(rsp_out_ts))
      else $error("stalled result word changed");

endmodule

bind timestep_window_slot_manager_unit twsm_chk u_twsm_chk (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_response (rsp_response),
   .rsp_slot     (rsp_slot),
   .rsp_out_ts   (rsp_out_ts),
   .rsp_last     (rsp_last)
);

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the timestep window slot manager. A predictor keeps
// its own slot table, pins and last-good timestep and works out the result
// words of every accepted input word; a checker compares each result word
// field by field. Directed tests cover the disabled block, serving order,
// pending hits, completions and a saturated window; random phases run
// playhead, completion, sample and query sequences under several settings.
// ----------------------------------------------------------------------------
module testbench;

   localparam int SLOTS      = 128;
   localparam int WDOG_LIMIT = 40000;
   localparam int SETTLE     = 40;
   localparam int HOLD_LEN   = 600;

   typedef struct {
      logic [2:0]  response;
      logic [6:0]  slot;
      logic [22:0] out_ts;
      logic        last;
   } result_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid, req_ready;
   logic [2:0]  req_kind;
   logic [23:0] req_ts;
   logic [1:0]  req_direction;
   logic [6:0]  req_done_slot;
   logic        rsp_valid, rsp_ready;
   logic [2:0]  rsp_response;
   logic [6:0]  rsp_slot;
   logic [22:0] rsp_out_ts;
   logic        rsp_last;
   logic        csr_valid, csr_ready;
   logic [1:0]  csr_index;
   logic [22:0] csr_wdata;

   // Predictor state
   logic [1:0]  cache_status [SLOTS];
   int          cache_ts     [SLOTS];
   logic [47:0] cache_stamp  [SLOTS];
   bit          cache_served [SLOTS];
   logic [47:0] use_count;
   int          pin_a, pin_b, good_ts;
   bit          cfg_enabled;
   int          cfg_num, cfg_stride, cfg_look;

   result_type  fresh_q[$];
   result_type  pending_q[$];

   int  errors = 0;
   int  words_sent = 0;
   int  results_seen = 0;
   int  load_requests = 0;
   int  hold_cycles = 0;
   int  hold_asks = 0;
   int  hold_seen = 0;
   bit  steady = 1'b0;
   bit  req_held = 1'b0;
   int  quiet = 0;

   timestep_window_slot_manager_unit #(.SLOTS(SLOTS)) u_dut (.*);

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor
   function automatic bit ts_valid(int t);
      return t >= 0 && t < cfg_num;
   endfunction

   function automatic int stride_used();
      return cfg_stride == 0 ? 1 : cfg_stride;
   endfunction

   function automatic bit is_key(int t);
      return ts_valid(t) && (t % stride_used()) == 0;
   endfunction

   function automatic int slot_of(int t);
      if (t < 0) return -1;
      for (int i = 0; i < SLOTS; i++)
         if (cache_status[i] != twsm_pkg::ST_FREE && cache_ts[i] == t) return i;
      return -1;
   endfunction

   function automatic void add_result(logic [2:0] r, int s, int t);
      result_type w;
      w.response = r;
      w.slot     = s[6:0];
      w.out_ts   = t[22:0];
      w.last     = 1'b0;
      fresh_q.push_back(w);
   endfunction

   function automatic int pick_victim();
      int best;
      best = -1;
      for (int i = 0; i < SLOTS; i++)
         if (cache_status[i] == twsm_pkg::ST_FREE) return i;
      for (int i = 0; i < SLOTS; i++)
         if (cache_status[i] == twsm_pkg::ST_RESIDENT && cache_ts[i] != pin_a
             && cache_ts[i] != pin_b && !cache_served[i]
             && (best < 0 || cache_stamp[i] < cache_stamp[best]))
            best = i;
      return best;
   endfunction

   function automatic void ask_load(int t);
      int s;
      if (!ts_valid(t) || slot_of(t) >= 0 || is_key(t)) return;
      s = pick_victim();
      if (s < 0) return;
      use_count       = use_count + 48'd1;
      cache_status[s] = twsm_pkg::ST_PENDING;
      cache_ts[s]     = t;
      cache_stamp[s]  = use_count;
      add_result(twsm_pkg::R_LOAD, s, t);
   endfunction

   // 0 nothing servable, 1 resident slot (touched), 2 keyframe
   function automatic int serve(int t, output int s);
      int f;
      f = slot_of(t);
      s = 0;
      if (f >= 0) begin
         if (cache_status[f] != twsm_pkg::ST_RESIDENT) return 0;
         use_count       = use_count + 48'd1;
         cache_stamp[f]  = use_count;
         cache_served[f] = 1'b1;
         s = f;
         return 1;
      end
      return is_key(t) ? 2 : 0;
   endfunction

   function automatic void playhead(int t, int d);
      int look;
      look = cfg_look > 60 ? 60 : cfg_look;
      if (look > SLOTS / 2) look = SLOTS / 2;
      pin_a = t;
      pin_b = t + 1 > 8388607 ? t + 1 - 16777216 : t + 1;
      ask_load(t);
      ask_load(t + 1);
      if (d > 0) begin
         for (int k = 2; k <= look; k++) ask_load(t + k);
      end else if (d < 0) begin
         for (int k = 1; k <= look; k++) ask_load(t - k);
      end else begin
         for (int k = 1; k <= look / 2; k++) begin
            ask_load(t + k);
            ask_load(t - k);
         end
      end
   endfunction

   function automatic void sample(int t);
      int s, r;
      longint unsigned st, q, kf, kmax;
      if (!cfg_enabled || !ts_valid(t)) begin
         add_result(twsm_pkg::R_NONE, 0, 0);
         return;
      end
      r = serve(t, s);
      if (r != 0) begin
         good_ts = t;
         if (r == 1) add_result(twsm_pkg::R_EXACT, s, t);
         else add_result(twsm_pkg::R_KEYFRAME, 0, t);
         return;
      end
      ask_load(t);
      if (good_ts >= 0) begin
         r = serve(good_ts, s);
         if (r == 1) begin
            add_result(twsm_pkg::R_LASTGOOD, s, good_ts);
            return;
         end
         if (r == 2) begin
            add_result(twsm_pkg::R_KEYFRAME, 0, good_ts);
            return;
         end
      end
      st   = stride_used();
      q    = (2 * longint'(t) + st) / (2 * st);
      kf   = q * st;
      kmax = (longint'(cfg_num - 1) / st) * st;
      if (kf > kmax) kf = kmax;
      add_result(twsm_pkg::R_KEYFRAME, 0, int'(kf));
   endfunction

   // Work out every result word of one accepted input word
   function automatic void predict_word(logic [2:0] kind, logic [23:0] ts,
                                        logic [1:0] dir, logic [6:0] done);
      int  t, d, s;
      bit  hit;
      t = $signed(ts);
      d = $signed(dir);
      fresh_q.delete();
      case (kind)
         twsm_pkg::K_PLAYHEAD: begin
            if (cfg_enabled) playhead(t, d);
            add_result(twsm_pkg::R_DONE, 0, 0);
         end
         twsm_pkg::K_SAMPLE: sample(t);
         twsm_pkg::K_QUERY: begin
            hit = cfg_enabled && ts_valid(t) && serve(t, s) != 0;
            add_result(hit ? twsm_pkg::R_PRESENT : twsm_pkg::R_ABSENT, 0, 0);
         end
         twsm_pkg::K_LOADDONE: begin
            if (cache_status[done] == twsm_pkg::ST_PENDING)
               cache_status[done] = twsm_pkg::ST_RESIDENT;
            add_result(twsm_pkg::R_DONE, 0, 0);
         end
         twsm_pkg::K_FRAME: begin
            foreach (cache_served[i]) cache_served[i] = 1'b0;
            add_result(twsm_pkg::R_DONE, 0, 0);
         end
         default: add_result(twsm_pkg::R_DONE, 0, 0);
      endcase
      fresh_q[$].last = 1'b1;
      foreach (fresh_q[i]) begin
         if (fresh_q[i].response == twsm_pkg::R_LOAD) load_requests++;
         pending_q.push_back(fresh_q[i]);
      end
   endfunction

   // ----------------------------------------------------------------- checker
   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d want %0d (result %0d)", what, got, want,
               results_seen);
      errors++;
   endtask

   always @(posedge clock) begin
      result_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_q.size() == 0) begin
            report_mismatch("unexpected word, response", rsp_response, -1);
         end else begin
            w = pending_q.pop_front();
            if (rsp_response !== w.response) report_mismatch("response", rsp_response, w.response);
            if (rsp_slot !== w.slot)         report_mismatch("slot", rsp_slot, w.slot);
            if (rsp_out_ts !== w.out_ts)     report_mismatch("out_ts", rsp_out_ts, w.out_ts);
            if (rsp_last !== w.last)         report_mismatch("last", rsp_last, w.last);
         end
         results_seen++;
      end
   end

   // Receiver: random stalls, long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_asks != hold_seen) begin
         rsp_ready   <= 1'b0;
         hold_cycles <= HOLD_LEN;
         hold_seen   <= hold_asks;
      end else if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else if (steady) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= $urandom_range(99) >= 35;
      end
   end

   // Watchdog: end the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= WDOG_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet);
         $display("testbench: done, errors");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // ---------------------------------------------------------------- drivers
   task automatic release_req();
      if (req_held) begin
         req_valid <= 1'b0;
         req_held = 1'b0;
      end
   endtask

   task automatic send_word(logic [2:0] kind, logic [23:0] ts, logic [1:0] dir,
                            logic [6:0] done);
      // idle a random number of cycles
      if (!steady && $urandom_range(99) < 35) begin
         release_req();
         do @(posedge clock); while ($urandom_range(99) < 35);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_ts        <= ts;
      req_direction <= dir;
      req_done_slot <= done;
      req_held = 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_word(kind, ts, dir, done);
      words_sent++;
   endtask

   task automatic wait_idle();
      release_req();
      @(posedge clock);
      while (pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_regs(bit en, int num, int stride, int look);
      logic [22:0] vals[4];
      wait_idle();
      vals = '{23'(en), 23'(num), 23'(stride), 23'(look)};
      csr_valid <= 1'b1;
      for (int i = 0; i < 4; i++) begin
         csr_index <= 2'(i);
         csr_wdata <= vals[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      cfg_enabled = en;
      cfg_num     = num & 32'h7FFFFF;
      cfg_stride  = stride & 32'h7FFFFF;
      cfg_look    = look & 63;
   endtask

   // Complete one pending load, or poke a random slot when none is pending
   task automatic complete_one();
      int p[$];
      foreach (cache_status[i]) if (cache_status[i] == twsm_pkg::ST_PENDING) p.push_back(i);
      if (p.size() != 0)
         send_word(twsm_pkg::K_LOADDONE, 24'($urandom), 2'($urandom),
                   7'(p[$urandom_range(p.size() - 1)]));
      else
         send_word(twsm_pkg::K_LOADDONE, 24'($urandom), 2'($urandom), 7'($urandom));
   endtask

   task automatic complete_all();
      for (int i = 0; i < SLOTS; i++)
         if (cache_status[i] == twsm_pkg::ST_PENDING)
            send_word(twsm_pkg::K_LOADDONE, 24'd0, 2'd0, 7'(i));
   endtask

   // ------------------------------------------------------------------- tests
   task automatic test_disabled();
      send_word(twsm_pkg::K_PLAYHEAD, 24'd5, 2'b01, 7'd0);
      send_word(twsm_pkg::K_SAMPLE, 24'h7FFFFF, 2'd0, 7'd0);
      send_word(twsm_pkg::K_QUERY, 24'h800000, 2'd0, 7'd0);
      send_word(twsm_pkg::K_LOADDONE, 24'd0, 2'd0, 7'd127);
      send_word(twsm_pkg::K_FRAME, 24'hFFFFFF, 2'b11, 7'd0);
      for (int k = 5; k < 8; k++) send_word(3'(k), 24'd0, 2'd0, 7'd0);
   endtask

   task automatic test_serving();
      write_regs(1'b1, 40, 8, 4);
      send_word(twsm_pkg::K_PLAYHEAD, 24'd10, 2'b01, 7'd0);
      send_word(twsm_pkg::K_SAMPLE, 24'd10, 2'd0, 7'd0);        // pending hit, falls back
      complete_all();
      send_word(twsm_pkg::K_SAMPLE, 24'd10, 2'd0, 7'd0);        // exact resident
      send_word(twsm_pkg::K_SAMPLE, 24'd21, 2'd0, 7'd0);        // missing, last good
      send_word(twsm_pkg::K_QUERY, 24'd11, 2'd0, 7'd0);
      send_word(twsm_pkg::K_QUERY, 24'd16, 2'd0, 7'd0);         // keyframe present
      send_word(twsm_pkg::K_SAMPLE, 24'hFFFFFF, 2'd0, 7'd0);    // below range
      send_word(twsm_pkg::K_SAMPLE, 24'd40, 2'd0, 7'd0);        // above range
      send_word(twsm_pkg::K_LOADDONE, 24'd0, 2'd0, 7'd127);     // not pending
      send_word(twsm_pkg::K_PLAYHEAD, 24'd30, 2'b10, 7'd0);     // backward
      send_word(twsm_pkg::K_PLAYHEAD, 24'h7FFFFF, 2'b00, 7'd0); // still, top of ts
      send_word(twsm_pkg::K_FRAME, 24'd0, 2'd0, 7'd0);
      write_regs(1'b1, 37, 0, 2);                               // stride zero
      send_word(twsm_pkg::K_SAMPLE, 24'd36, 2'd0, 7'd0);
      write_regs(1'b1, 1000, 1000, 0);                          // nearest keyframe clamps
      send_word(twsm_pkg::K_SAMPLE, 24'd999, 2'd0, 7'd0);
   endtask

   task automatic test_saturation();
      write_regs(1'b1, 1000, 1000, 63);
      send_word(twsm_pkg::K_PLAYHEAD, 24'd100, 2'b01, 7'd0);
      send_word(twsm_pkg::K_PLAYHEAD, 24'd300, 2'b11, 7'd0);
      send_word(twsm_pkg::K_PLAYHEAD, 24'd500, 2'b00, 7'd0);
      complete_all();
      send_word(twsm_pkg::K_PLAYHEAD, 24'd700, 2'b01, 7'd0);    // evicts least recent
   endtask

   task automatic test_backpressure();
      write_regs(1'b1, 300, 16, 12);
      wait_idle();
      hold_asks = hold_asks + 1;
      for (int i = 0; i < 12; i++)
         send_word(twsm_pkg::K_PLAYHEAD, 24'(20 * i), 2'(i), 7'd0);
   endtask

   task automatic run_phase(bit en, int num, int stride, int look, int count, bit calm);
      int center, t, r;
      logic [1:0] d;
      write_regs(en, num, stride, look);
      steady = calm;
      center = num > 0 ? int'($urandom_range(num - 1)) : 0;
      repeat (count) begin
         r = $urandom_range(99);
         t = center + int'($urandom_range(2 * look + 6)) - look - 3;
         if (r < 15) begin
            send_word(3'($urandom), 24'($urandom), 2'($urandom), 7'($urandom));
         end else if (r < 30) begin
            d = 2'($urandom);
            center = center + ($signed(d) > 0 ? 2 : $signed(d) < 0 ? -2 : 0);
            send_word(twsm_pkg::K_PLAYHEAD, 24'(center), d, 7'($urandom));
         end else if (r < 52) begin
            complete_one();
         end else if (r < 77) begin
            send_word(twsm_pkg::K_SAMPLE, 24'(t), 2'($urandom), 7'($urandom));
         end else if (r < 90) begin
            send_word(twsm_pkg::K_QUERY, 24'(t), 2'($urandom), 7'($urandom));
         end else begin
            send_word(twsm_pkg::K_FRAME, 24'($urandom), 2'($urandom), 7'($urandom));
         end
      end
      steady = 1'b0;
   endtask

   task automatic test_random();
      run_phase(1'b1, 200, 10, 8, 25, 1'b0);
      run_phase(1'b1, 120, 0, 63, 20, 1'b1);
      run_phase(1'b1, 8388607, 8388607, 0, 20, 1'b0);
      run_phase(1'b0, 500, 5, 6, 10, 1'b0);
      run_phase(1'b1, 0, 1, 5, 10, 1'b0);
      run_phase(1'b1, 90, 3, 20, 35, 1'b0);
   endtask

   // -------------------------------------------------------------------- main
   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_kind      <= '0;
      req_ts        <= '0;
      req_direction <= '0;
      req_done_slot <= '0;
      csr_valid     <= 1'b0;
      csr_index     <= '0;
      csr_wdata     <= '0;
      foreach (cache_status[i]) begin
         cache_status[i] = twsm_pkg::ST_FREE;
         cache_ts[i]     = 0;
         cache_stamp[i]  = '0;
         cache_served[i] = 1'b0;
      end
      use_count   = '0;
      pin_a       = -1;
      pin_b       = -1;
      good_ts     = -1;
      cfg_enabled = 1'b0;
      cfg_num     = 0;
      cfg_stride  = 1;
      cfg_look    = 16;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_disabled();
      test_serving();
      test_saturation();
      test_backpressure();
      test_random();
      wait_idle();

      $display("covered %0d input words, %0d result words, %0d load requests",
               words_sent, results_seen, load_requests);
      $display("settings: disabled, stride zero and max, lookahead 0..63, full window");
      if (errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
